### rtl/mis_pkg.sv
// ----------------------------------------------------------------------------
// mis_pkg: shared definitions for the magnitude insertion sorter
// Store depth, field widths, direction codes, cell control bundles and the
// saturating magnitude function used at the input.
// ----------------------------------------------------------------------------
package mis_pkg;

   localparam int MAX_LEN    = 64;
   localparam int SAMPLE_W   = 32;
   localparam int MAG_W      = 31;
   localparam int CNT_W      = $clog2(MAX_LEN + 1);
   localparam int DIR_W      = 2;
   localparam int RSP_DATA_W = ((MAG_W + 7) / 8) * 8;

   localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

   // Direction register codes; both negative codes sort descending.
   localparam logic [DIR_W-1:0] DIR_REVERSE     = 2'b00;
   localparam logic [DIR_W-1:0] DIR_ASCEND      = 2'b01;
   localparam logic [DIR_W-1:0] DIR_DESCEND_ALT = 2'b10;
   localparam logic [DIR_W-1:0] DIR_DESCEND     = 2'b11;

   typedef logic [MAG_W-1:0] mag_type;
   typedef logic [CNT_W-1:0] cnt_type;

   // Comparison set-up handed to each cell.
   typedef struct packed {
      logic occupied;
      logic ascend;
      logic descend;
   } cell_cmp_type;

   // Update control handed to each cell.
   typedef struct packed {
      logic load;
      logic drain;
      logic keep;
      logic take_new;
   } cell_ctl_type;

   // Absolute value of a two's complement sample, saturated at the largest
   // positive value so that the most negative input still fits.
   function automatic mag_type magnitude_of(input logic [SAMPLE_W-1:0] v);
      logic [SAMPLE_W-1:0] m;
      m = v[SAMPLE_W-1] ? (~v + 1'b1) : v;
      if (m[SAMPLE_W-1]) begin
         return MAG_MAX;
      end
      return m[MAG_W-1:0];
   endfunction

endpackage

### rtl/mis_cell.sv
// ----------------------------------------------------------------------------
// mis_cell: one insertion cell of the sorting row
// Holds one magnitude, tells whether a new magnitude must go after it, and
// either keeps its value, takes the new one, takes its left neighbour's
// (insertion shift) or its right neighbour's (drain shift).
// ----------------------------------------------------------------------------
module mis_cell (
   input  logic                  clock,
   input  mis_pkg::mag_type      new_mag,
   input  mis_pkg::mag_type      left_mag,
   input  mis_pkg::mag_type      right_mag,
   input  mis_pkg::cell_cmp_type cmp,
   input  mis_pkg::cell_ctl_type ctl,
   output mis_pkg::mag_type      value,
   output logic                  follows
);

   mis_pkg::mag_type value_ff;
   mis_pkg::mag_type value_in;

   always_comb begin
      follows = cmp.occupied &
                ((cmp.ascend  & (value_ff <= new_mag)) |
                 (cmp.descend & (value_ff >= new_mag)));
   end

   always_comb begin
      value_in = value_ff;
      if (ctl.drain) begin
         value_in = right_mag;
      end else if (ctl.load && !ctl.keep) begin
         value_in = ctl.take_new ? new_mag : left_mag;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

### rtl/magnitude_insertion_sorter_core.sv
// Latency: a word's magnitude settles into its cell at the edge that accepts it; the first
// sorted word is offered on the cycle after the word marked last is taken.
// Throughput: one input word per cycle while loading, then one output word per cycle from
// the head of the cell row while rsp_tready is high; input is held off until the final word
// has gone.
// Reset clears the count, the overflow flag and the drain state and selects ascending order.
// ----------------------------------------------------------------------------
// magnitude_insertion_sorter_core: stable insertion sort of sample magnitudes, or reversal
// A row of cells keeps the magnitudes in order; the vector is shifted out on
// its last word, the final output word flagged with tlast.
// ----------------------------------------------------------------------------
module magnitude_insertion_sorter_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [mis_pkg::SAMPLE_W-1:0]          req_tdata,  // [31:0] sample_value
   input  logic                                  req_tlast,  // is_last
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mis_pkg::RSP_DATA_W-1:0]        rsp_tdata,  // [30:0] sorted_magnitude
   output logic                                  rsp_tlast,  // end_of_run
   output logic                                  rsp_tuser,  // [0] truncated
   input  logic                                  csr_wr_en,
   input  logic [mis_pkg::DIR_W-1:0]             csr_wr_data // direction
);

   logic [mis_pkg::DIR_W-1:0] dir_ff;
   mis_pkg::cnt_type          count_ff, count_in;
   logic                      overflow_ff, overflow_in;
   logic                      drain_ff, drain_in;

   logic                      req_fire, rsp_fire, full, insert, final_word;
   mis_pkg::mag_type          new_mag;
   mis_pkg::mag_type          cell_value [mis_pkg::MAX_LEN];
   logic [mis_pkg::MAX_LEN-1:0] follows;
   logic [mis_pkg::MAX_LEN-1:0] stay;

   assign req_tready = !drain_ff;
   assign rsp_tvalid = drain_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign full       = (count_ff == mis_pkg::CNT_W'(mis_pkg::MAX_LEN));
   assign insert     = req_fire && !full;
   assign final_word = (count_ff == mis_pkg::CNT_W'(1));
   assign new_mag    = mis_pkg::magnitude_of(req_tdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= mis_pkg::DIR_ASCEND;
      end else if (csr_wr_en) begin
         dir_ff <= csr_wr_data;
      end
   end

   // The new magnitude goes in front of the first entry it need not follow.
   genvar g;
   generate
      for (g = 0; g < mis_pkg::MAX_LEN; g++) begin : g_cell
         mis_pkg::cell_cmp_type cmp;
         mis_pkg::cell_ctl_type ctl;
         mis_pkg::mag_type      left_mag, right_mag;
         logic                  take_new;

         assign stay[g] = &follows[g:0];

         always_comb begin
            cmp.occupied = (mis_pkg::CNT_W'(g) < count_ff);
            cmp.ascend   = (dir_ff == mis_pkg::DIR_ASCEND);
            cmp.descend  = dir_ff[mis_pkg::DIR_W-1];
            ctl.load     = insert;
            ctl.drain    = rsp_fire;
            ctl.keep     = stay[g];
            ctl.take_new = take_new;
         end

         if (g == 0) begin : g_head
            assign take_new = 1'b1;
            assign left_mag = new_mag;
         end else begin : g_body
            assign take_new = stay[g-1];
            assign left_mag = cell_value[g-1];
         end

         if (g == mis_pkg::MAX_LEN - 1) begin : g_tail
            assign right_mag = cell_value[g];
         end else begin : g_inner
            assign right_mag = cell_value[g+1];
         end

         mis_cell u_cell (
            .clock     (clock),
            .new_mag   (new_mag),
            .left_mag  (left_mag),
            .right_mag (right_mag),
            .cmp       (cmp),
            .ctl       (ctl),
            .value     (cell_value[g]),
            .follows   (follows[g])
         );
      end
   endgenerate

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      drain_in    = drain_ff;
      if (req_fire) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
         if (req_tlast) begin
            drain_in = 1'b1;
         end
      end
      if (rsp_fire) begin
         count_in = count_ff - 1'b1;
         if (final_word) begin
            drain_in    = 1'b0;
            overflow_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         drain_ff    <= 1'b0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         drain_ff    <= drain_in;
      end
   end

   assign rsp_tdata = mis_pkg::RSP_DATA_W'(cell_value[0]);
   assign rsp_tlast = final_word;
   assign rsp_tuser = overflow_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= mis_pkg::CNT_W'(mis_pkg::MAX_LEN))
      else $error("element count beyond store depth");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      drain_ff |-> (count_ff != '0))
      else $error("output word offered from an empty store");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && final_word) |=> (count_ff == '0) && !overflow_ff && !drain_ff)
      else $error("store not cleared after final word");

   a_overflow_set: assert property (@(posedge clock) disable iff (reset)
      (req_fire && full) |=> overflow_ff)
      else $error("dropped word not flagged");

endmodule
